### hdl/cmdm_pkg.sv
// Shared constants, types and helpers for the constellation map/demap block.
package cmdm_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int PartW     = 16;
  localparam int EntryW    = 2 * PartW;
  localparam int SizeW     = 7;
  localparam int BpsW      = 4;
  localparam int IdxW      = 8;
  localparam int NearW     = 6;
  localparam int DiffW     = PartW + 1;
  localparam int SqW       = 2 * PartW + 1;
  localparam int DistW     = SqW + 1;

  localparam logic [BpsW-1:0]  BpsReset  = BpsW'(6);
  localparam logic [SizeW-1:0] SizeReset = SizeW'(64);

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdMap   = 2'd1,
    CmdDemap = 2'd2
  } cmd_e;

  typedef enum logic {
    RegSize = 1'b0,
    RegBps  = 1'b1
  } reg_e;

  // Low-bit mask for symbol indexes; widths above eight act as eight.
  function automatic logic [IdxW-1:0] idx_mask(input logic [BpsW-1:0] bps);
    logic [IdxW:0] one_hot;
    logic [BpsW-1:0] b;
    b = (bps > BpsW'(IdxW)) ? BpsW'(IdxW) : bps;
    one_hot = (IdxW+1)'(1) << b;
    return IdxW'(one_hot - (IdxW+1)'(1));
  endfunction

endpackage

### hdl/cmdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmdm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/constellation_map_demap_core.sv
// Constellation map/demap core: point table in RAM, nearest-point sweep for demap.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | cmd, symbol_index, point_real, point_imag
//   out     | output    | out_valid_o/out_stall_i | mapped_real, mapped_imag, nearest_index, bad
//   cfg     | input     | cfg_we_i (no wait)     | cfg_index_i, cfg_wdata_i
//
// One request at a time. Load, unused commands and out-of-range maps go straight to done;
// map reads its entry, demap sweeps unless the size is 0: the sweep issues one table read
// per cycle on the single RAM read port, then a two-stage square/compare pipeline drains.
// The table has no reset and no clearing pass; entries are valid once loaded.
// A finished result waits in the output register while the next request is taken.
module constellation_map_demap_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic [cmdm_pkg::SizeW-1:0]            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            cmd_i,
  input  logic [cmdm_pkg::IdxW-1:0]             symbol_index_i,
  input  logic signed [cmdm_pkg::PartW-1:0]     point_real_i,
  input  logic signed [cmdm_pkg::PartW-1:0]     point_imag_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cmdm_pkg::PartW-1:0]     mapped_real_o,
  output logic signed [cmdm_pkg::PartW-1:0]     mapped_imag_o,
  output logic [cmdm_pkg::NearW-1:0]            nearest_index_o,
  output logic                                  bad_symbol_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMapRd = 5'b00010,
    StSweep = 5'b00100,
    StDrain = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [cmdm_pkg::SizeW-1:0] cfg_size_q;
  logic [cmdm_pkg::BpsW-1:0]  cfg_bps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= cmdm_pkg::SizeReset;
      cfg_bps_q  <= cmdm_pkg::BpsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cmdm_pkg::RegSize: cfg_size_q <= cfg_wdata_i;
        cmdm_pkg::RegBps:  cfg_bps_q  <= cfg_wdata_i[cmdm_pkg::BpsW-1:0];
        default: ;
      endcase
    end
  end

  logic [cmdm_pkg::SizeW-1:0] size_eff;
  logic [cmdm_pkg::IdxW-1:0]  mask;
  logic [cmdm_pkg::IdxW-1:0]  sym_masked;
  logic                       map_bad;
  logic                       load_ok;
  logic                       in_accept;

  assign size_eff = (cfg_size_q > cmdm_pkg::SizeW'(cmdm_pkg::MaxPoints))
                    ? cmdm_pkg::SizeW'(cmdm_pkg::MaxPoints) : cfg_size_q;
  assign mask       = cmdm_pkg::idx_mask(cfg_bps_q);
  assign sym_masked = symbol_index_i & mask;
  assign map_bad    = {1'b0, sym_masked} >= (cmdm_pkg::IdxW+1)'(size_eff);
  assign load_ok    = {1'b0, symbol_index_i} < (cmdm_pkg::IdxW+1)'(cmdm_pkg::MaxPoints);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  // Point table
  logic                            ram_we;
  logic                            ram_re;
  logic [cmdm_pkg::AddrW-1:0]      ram_raddr;
  logic [cmdm_pkg::EntryW-1:0]     ram_rdata;
  logic [cmdm_pkg::AddrW-1:0]      cnt_q;

  assign ram_we = in_accept && (cmd_i == cmdm_pkg::CmdLoad) && load_ok;
  assign ram_re = (in_accept && (cmd_i == cmdm_pkg::CmdMap) && !map_bad)
                  || (state_q == StSweep);
  assign ram_raddr = (state_q == StSweep) ? cnt_q : sym_masked[cmdm_pkg::AddrW-1:0];

  cmdm_ram #(
    .Width(cmdm_pkg::EntryW),
    .Depth(cmdm_pkg::MaxPoints)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(symbol_index_i[cmdm_pkg::AddrW-1:0]),
    .wdata_i({point_real_i, point_imag_i}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sweep and distance pipeline
  logic signed [cmdm_pkg::PartW-1:0] rx_re_q, rx_im_q;
  logic                              v1_q, v2_q;
  logic [cmdm_pkg::AddrW-1:0]        idx1_q, idx2_q;
  logic [cmdm_pkg::SqW-1:0]          sq_re_q, sq_im_q;
  logic                              found_q;
  logic [cmdm_pkg::DistW-1:0]        best_dist_q;
  logic [cmdm_pkg::AddrW-1:0]        best_idx_q;
  logic                              last_issue;

  logic signed [cmdm_pkg::DiffW-1:0]   dr, di;
  logic signed [2*cmdm_pkg::DiffW-1:0] pr, pi;
  logic [cmdm_pkg::DistW-1:0]          cand_dist;

  assign dr = cmdm_pkg::DiffW'(rx_re_q)
            - cmdm_pkg::DiffW'($signed(ram_rdata[cmdm_pkg::EntryW-1:cmdm_pkg::PartW]));
  assign di = cmdm_pkg::DiffW'(rx_im_q)
            - cmdm_pkg::DiffW'($signed(ram_rdata[cmdm_pkg::PartW-1:0]));
  assign pr = dr * dr;
  assign pi = di * di;
  assign cand_dist = cmdm_pkg::DistW'(sq_re_q) + cmdm_pkg::DistW'(sq_im_q);
  assign last_issue = ({1'b0, cnt_q} == cmdm_pkg::SizeW'(size_eff - cmdm_pkg::SizeW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= (state_q == StSweep);
      v2_q <= v1_q;
      if (in_accept) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == StSweep) begin
        cnt_q <= cnt_q + cmdm_pkg::AddrW'(1);
      end
      if (v2_q && (!found_q || cand_dist < best_dist_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rx_re_q <= point_real_i;
      rx_im_q <= point_imag_i;
    end
    idx1_q  <= cnt_q;
    idx2_q  <= idx1_q;
    sq_re_q <= pr[cmdm_pkg::SqW-1:0];
    sq_im_q <= pi[cmdm_pkg::SqW-1:0];
    // strict compare keeps the lowest index on a tie
    if (v2_q && (!found_q || cand_dist < best_dist_q)) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= idx2_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (cmd_i == cmdm_pkg::CmdMap && !map_bad) begin
            state_d = StMapRd;
          end else if (cmd_i == cmdm_pkg::CmdDemap && size_eff != '0) begin
            state_d = StSweep;
          end else begin
            state_d = StDone;
          end
        end
      end
      StMapRd: state_d = StDone;
      StSweep: begin
        if (last_issue) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!v1_q && !v2_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Pending result
  logic signed [cmdm_pkg::PartW-1:0] res_re_q, res_im_q;
  logic [cmdm_pkg::NearW-1:0]        res_idx_q;
  logic                              res_bad_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_re_q  <= '0;
      res_im_q  <= '0;
      res_idx_q <= '0;
      res_bad_q <= (cmd_i == cmdm_pkg::CmdMap) && map_bad;
    end else if (state_q == StMapRd) begin
      res_re_q <= $signed(ram_rdata[cmdm_pkg::EntryW-1:cmdm_pkg::PartW]);
      res_im_q <= $signed(ram_rdata[cmdm_pkg::PartW-1:0]);
    end else if (state_q == StDrain && !v1_q && !v2_q) begin
      res_idx_q <= cmdm_pkg::NearW'(best_idx_q) & mask[cmdm_pkg::NearW-1:0];
    end
  end

  // Output register
  logic                              out_valid_q;
  logic signed [cmdm_pkg::PartW-1:0] out_re_q, out_im_q;
  logic [cmdm_pkg::NearW-1:0]        out_idx_q;
  logic                              out_bad_q;
  logic                              out_load;

  assign out_load = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_q  <= res_re_q;
      out_im_q  <= res_im_q;
      out_idx_q <= res_idx_q;
      out_bad_q <= res_bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mapped_real_o   = out_re_q;
  assign mapped_imag_o   = out_im_q;
  assign nearest_index_o = out_idx_q;
  assign bad_symbol_o    = out_bad_q;

  // Checks
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != StIdle))
    else $error("accepted request did not start");

  a_pipe_in_demap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> (state_q == StSweep || state_q == StDrain))
    else $error("distance pipeline active outside demap");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_symbol_o) |-> (mapped_real_o == '0 && mapped_imag_o == '0))
    else $error("bad symbol result carries a point");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("table write and read in the same cycle");

endmodule
